// ===== rtl/rgde_pkg.sv =====
// shared types and defaults for the run geometry delta encoder
// no dependencies

package rgde_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int LEN_BITS_DEF   = 16;
    localparam int FIELD_BITS     = 16;

    // one cell run presented at the input
    typedef struct packed {
        logic [FIELD_BITS-1:0] start_row;
        logic [FIELD_BITS-1:0] start_col;
        logic [FIELD_BITS-1:0] run_length;
        logic                  new_blip;
        logic                  restart;
    } run_t;

    // one byte of the compressed stream
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } code_t;

    // control flags from the serializer: load strobe and frame busy
    typedef struct packed {
        logic load;
        logic busy;
    } frame_ctl_t;

endpackage

// ===== rtl/rgde_encode.sv =====
// position tracking and frame build for one cell run
// depends on rgde_pkg

module rgde_encode
    import rgde_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF,
    parameter int MAXB       = 2 + 2 * ((COORD_BITS + 7) / 8) + (LEN_BITS + 7) / 8,
    parameter int CNTW       = $clog2(MAXB + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  run_t             run,
    input  logic             load,
    output logic [7:0]       frame [MAXB],
    output logic [CNTW-1:0]  count
);

    localparam int CB   = (COORD_BITS + 7) / 8;
    localparam int LB   = (LEN_BITS + 7) / 8;
    localparam int POSL = 1 + 2 * CB;

    logic [COORD_BITS-1:0] prev_row_reg, prev_row_next;
    logic [COORD_BITS-1:0] prev_col_reg, prev_col_next;

    logic [COORD_BITS-1:0] row, col, base_row, base_col;
    logic [LEN_BITS-1:0]   len;
    logic [CB*8-1:0]       row_x, col_x;
    logic [LB*8-1:0]       len_x;
    logic [COORD_BITS:0]   dr, dc;
    logic                  pos_short, len_short;
    logic [7:0]            lenb [LB+1];

    assign row = COORD_BITS'(run.start_row);
    assign col = COORD_BITS'(run.start_col);
    assign len = LEN_BITS'(run.run_length);

    assign row_x = (CB*8)'(row);
    assign col_x = (CB*8)'(col);
    assign len_x = (LB*8)'(len);

    // restart drops the reference back to the origin
    assign base_row = run.restart ? '0 : prev_row_reg;
    assign base_col = run.restart ? '0 : prev_col_reg;

    // exact signed differences, one bit wider than the coordinates
    assign dr = {1'b0, row} - {1'b0, base_row};
    assign dc = {1'b0, col} - {1'b0, base_col};

    // dr fits 2 signed bits, dc fits 6, and not both zero
    assign pos_short = (dr[COORD_BITS:1] == {COORD_BITS{dr[1]}})
                    && (dc[COORD_BITS:5] == {(COORD_BITS-4){dc[5]}})
                    && !((dr == '0) && (dc == '0));

    assign len_short = (len != '0) && (len[LEN_BITS-1:7] == '0);

    always_comb
    begin
        lenb[0] = len_short ? {run.new_blip, len[6:0]} : {run.new_blip, 7'b0};
        for (int i = 0; i < LB; i++)
        begin
            lenb[i+1] = len_x[8*i +: 8];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAXB; i++)
        begin
            frame[i] = 8'h00;
        end
        if (pos_short)
        begin
            frame[0] = {dr[1:0], dc[5:0]};
            frame[1] = lenb[0];
            for (int j = 0; j < LB; j++)
            begin
                frame[2+j] = lenb[j+1];
            end
        end
        else
        begin
            for (int i = 0; i < CB; i++)
            begin
                frame[1+i]    = row_x[8*i +: 8];
                frame[1+CB+i] = col_x[8*i +: 8];
            end
            for (int j = 0; j <= LB; j++)
            begin
                frame[POSL+j] = lenb[j];
            end
        end
        count = (pos_short ? CNTW'(1) : CNTW'(POSL))
              + (len_short ? CNTW'(1) : CNTW'(1 + LB));
    end

    always_comb
    begin
        prev_row_next = prev_row_reg;
        prev_col_next = prev_col_reg;
        if (load)
        begin
            prev_row_next = row;
            prev_col_next = col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_row_reg <= '0;
            prev_col_reg <= '0;
        end
        else
        begin
            prev_row_reg <= prev_row_next;
            prev_col_reg <= prev_col_next;
        end
    end

endmodule

// ===== rtl/rgde_serial.sv =====
// frame register and byte serializer
// depends on rgde_pkg

module rgde_serial
    import rgde_pkg::*;
#(
    parameter int MAXB = 8,
    parameter int CNTW = $clog2(MAXB + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       frame [MAXB],
    input  logic [CNTW-1:0]  count,
    input  logic             load,
    output frame_ctl_t       ctl,
    output logic             code_valid,
    input  logic             code_ready,
    output code_t            code
);

    localparam int IDXW = $clog2(MAXB);

    logic [7:0]      frame_reg [MAXB];
    logic [CNTW-1:0] count_reg;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic            last, take;

    assign last = (CNTW'(idx_reg) + CNTW'(1)) == count_reg;
    assign take = valid_reg && code_ready;

    assign code_valid     = valid_reg;
    assign code.out_byte  = frame_reg[idx_reg];
    assign code.last_byte = last;

    // free when empty or when the final byte leaves this cycle
    assign ctl.busy = valid_reg && !(take && last);
    assign ctl.load = load;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + IDXW'(1);
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame;
            count_reg <= count;
        end
    end

endmodule

// ===== rtl/run_geometry_delta_encoder_unit.sv =====
// top level of the run geometry delta encoder
// depends on rgde_pkg, rgde_encode, rgde_serial

// Encodes one cell run per request into a compressed byte stream. The run's
// position goes out as one packed delta byte (2 signed row bits, 6 signed
// column bits) against the previous run, or as a zero flag byte followed by
// the absolute row and column, low byte first; a zero delta always uses the
// absolute form. The length follows as one byte (1..127, top bit marks a
// blip start) or as a flag byte followed by the full length. The restart
// bit sets the reference position to the origin before encoding. Each
// request yields 2 to 2 + 2*ceil(COORD_BITS/8) + ceil(LEN_BITS/8) bytes (2
// for a typical run, 8 at most with default parameters), sent one byte per
// cycle on the code channel while code_ready is high. The rate is set by
// the single byte lane of the serializer; the next request is taken in the
// same cycle that the previous one's last byte is accepted, so a waiting
// request follows on the code channel without a gap between frames.

module run_geometry_delta_encoder_unit
    import rgde_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  run_valid,
    output logic  run_ready,
    input  run_t  run,
    output logic  code_valid,
    input  logic  code_ready,
    output code_t code
);

    // longest frame: flag, two coordinates, length flag, full length
    localparam int MAXB = 2 + 2 * ((COORD_BITS + 7) / 8) + (LEN_BITS + 7) / 8;
    localparam int CNTW = $clog2(MAXB + 1);

    logic [7:0]      frame [MAXB];
    logic [CNTW-1:0] count;
    logic            load;
    frame_ctl_t      ctl;

    // request taken whenever the frame register frees up this cycle
    assign run_ready = !ctl.busy;
    assign load      = run_valid && run_ready;

    // delta check and frame build against the stored position
    rgde_encode #(
        .COORD_BITS (COORD_BITS),
        .LEN_BITS   (LEN_BITS),
        .MAXB       (MAXB),
        .CNTW       (CNTW)
    ) u_encode (
        .clk   (clk),
        .rst_n (rst_n),
        .run   (run),
        .load  (load),
        .frame (frame),
        .count (count)
    );

    // frame register and one byte per cycle out while code_ready is high
    rgde_serial #(
        .MAXB (MAXB),
        .CNTW (CNTW)
    ) u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .count      (count),
        .load       (load),
        .ctl        (ctl),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

endmodule
